FILE: sv/sfrc_pkg.sv
// Shared constants, result type and the byte-wide CRC-16 update for the
// serial frame receive checker. No dependencies.
package sfrc_pkg;

    localparam int PAYLOAD_BYTES = 4;
    localparam int HDR_BYTES     = 3;
    localparam int KEPT_BYTES    = (PAYLOAD_BYTES < 4) ? PAYLOAD_BYTES : 4;
    localparam int CRC_LO_POS    = HDR_BYTES + PAYLOAD_BYTES + 1;
    localparam int IDX_W         = $clog2(CRC_LO_POS + 1);

    localparam logic [7:0]  SYNC_BYTE = 8'h55;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  MAX_CMD   = 8'd9;
    localparam logic [7:0]  CMD_LEFT  = 8'd1;
    localparam logic [7:0]  CMD_RIGHT = 8'd2;

    typedef struct packed {
        logic        valid;
        logic [3:0]  cmd;
        logic [2:0]  len;
        logic [31:0] payload;
        logic [15:0] pair;
    } t_result;

    // CCITT-FALSE update: MSB first, no reflection.
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                 input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/serial_frame_receive_checker_core.sv
// Top level of the serial frame receive checker: input register, deframer
// and result register. Depends on sfrc_pkg and sfrc_deframer.
//
//   Channel  Direction  Handshake                  Payload
//   in       request    i_in_valid / o_in_stall    i_rx_byte
//   out      result     o_out_valid / i_out_stall  o_frame_cmd, o_data_len,
//                                                  o_frame_payload, o_pair_count
//
// One byte is taken per cycle while the input is not stalled. A byte is
// registered, then the CRC update and the frame check run combinationally
// between the input register and the result register, which captures the result.
// Reset is synchronous and active low and returns the deframer to sync hunting.
// A stalled result holds the input register, which then stalls the input.
module serial_frame_receive_checker_core
    import sfrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_frame_cmd,
    output logic [2:0]  o_data_len,
    output logic [31:0] o_frame_payload,
    output logic [15:0] o_pair_count
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    res;
    logic       out_blocked;
    logic       advance;

    assign out_blocked = r_out_valid && i_out_stall;
    assign advance     = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;

    sfrc_deframer u_deframer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_cmd     = r_out.cmd;
    assign o_data_len      = r_out.len;
    assign o_frame_payload = r_out.payload;
    assign o_pair_count    = r_out.pair;

endmodule

FILE: sv/sfrc_deframer.sv
// Frame state, CRC accumulation and frame check for the receive checker.
// Depends on sfrc_pkg.
module sfrc_deframer
    import sfrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_pay [4], n_pay [4];
    logic [7:0]       r_crc_hi, n_crc_hi;
    logic             r_left, n_left;
    logic [15:0]      r_pair, n_pair;

    logic [IDX_W-1:0] pay_k;
    logic [15:0]      crc_upd;
    logic [15:0]      got_crc;

    assign crc_upd = crc_add_byte(r_crc, i_byte);
    assign pay_k   = r_idx - IDX_W'(HDR_BYTES);
    assign got_crc = {r_crc_hi, i_byte};

    always_comb begin
        n_idx    = r_idx;
        n_crc    = r_crc;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_pay    = r_pay;
        n_crc_hi = r_crc_hi;
        n_left   = r_left;
        n_pair   = r_pair;
        o_res    = '0;

        if (r_idx == '0) begin
            if (i_byte == SYNC_BYTE) begin
                n_crc = crc_add_byte(CRC_INIT, i_byte);
                for (int j = 0; j < 4; j++) begin
                    n_pay[j] = 8'h00;
                end
                n_idx = IDX_W'(1);
            end
        end else if (r_idx == IDX_W'(1)) begin
            n_cmd = i_byte;
            n_crc = crc_upd;
            n_idx = IDX_W'(2);
        end else if (r_idx == IDX_W'(2)) begin
            n_len = i_byte;
            n_crc = crc_upd;
            n_idx = IDX_W'(3);
        end else if (r_idx < IDX_W'(HDR_BYTES + PAYLOAD_BYTES)) begin
            for (int j = 0; j < KEPT_BYTES; j++) begin
                if (r_idx == IDX_W'(HDR_BYTES + j)) begin
                    n_pay[j] = i_byte;
                end
            end
            // Only the first "length" payload bytes are covered by the CRC.
            if (8'(pay_k) < r_len) begin
                n_crc = crc_upd;
            end
            n_idx = r_idx + IDX_W'(1);
        end else if (r_idx < IDX_W'(CRC_LO_POS)) begin
            n_crc_hi = i_byte;
            n_idx    = r_idx + IDX_W'(1);
        end else begin
            n_idx = '0;
            n_crc = CRC_INIT;
            if (r_len != 8'd0 && r_len <= 8'(PAYLOAD_BYTES) && got_crc == r_crc
                    && r_cmd != 8'd0 && r_cmd <= MAX_CMD) begin
                if (r_cmd == CMD_LEFT) begin
                    n_left = 1'b1;
                end else if (r_cmd == CMD_RIGHT && r_left) begin
                    n_pair = r_pair + 16'd1;
                    n_left = 1'b0;
                end
                o_res.valid   = 1'b1;
                o_res.cmd     = r_cmd[3:0];
                o_res.len     = r_len[2:0];
                o_res.payload = {r_pay[3], r_pay[2], r_pay[1], r_pay[0]};
                o_res.pair    = n_pair;
            end
        end

        if (!i_en) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_crc    <= CRC_INIT;
            r_cmd    <= '0;
            r_len    <= '0;
            r_crc_hi <= '0;
            r_left   <= 1'b0;
            r_pair   <= '0;
            for (int j = 0; j < 4; j++) begin
                r_pay[j] <= '0;
            end
        end else if (i_en) begin
            r_idx    <= n_idx;
            r_crc    <= n_crc;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_crc_hi <= n_crc_hi;
            r_left   <= n_left;
            r_pair   <= n_pair;
            r_pay    <= n_pay;
        end
    end

endmodule

FILE: dv/tb_serial_frame_receive_checker_core.sv
`timescale 1ns / 1ps
// Testbench for serial_frame_receive_checker_core: byte-level stimulus, a deframing
// predictor with its own CRC-16 and a result scoreboard. Depends on sfrc_pkg and the core.
module tb_serial_frame_receive_checker_core;
    import sfrc_pkg::*;

    localparam int RANDOM_BYTES   = 160;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_CYCLES   = 20;
    localparam int EMPTY_GUARD    = 5000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [3:0]  cmd;
        logic [2:0]  len;
        logic [31:0] payload;
        logic [15:0] pairs;
    } t_frame_result;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  frame_cmd;
    logic [2:0]  data_len;
    logic [31:0] frame_payload;
    logic [15:0] pair_count;

    // Deframer state as predicted.
    logic [3:0]  p_idx;
    logic [15:0] p_crc;
    logic [7:0]  p_cmd;
    logic [7:0]  p_len;
    logic [31:0] p_payload;
    logic [7:0]  p_crc_hi;
    logic        p_left_fresh;
    logic [15:0] p_pairs;

    t_frame_result expected_frames[$];
    int  failures         = 0;
    int  bytes_framed     = 0;
    bit  pace_random      = 1'b0;
    bit  long_hold_req    = 1'b0;
    bit  hold_block       = 1'b0;
    bit  result_taken     = 1'b0;

    serial_frame_receive_checker_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_frame_cmd     (frame_cmd),
        .o_data_len      (data_len),
        .o_frame_payload (frame_payload),
        .o_pair_count    (pair_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bitwise CCITT-FALSE: feedback is the CRC top bit xor the incoming data bit.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    function automatic logic [15:0] frame_crc(input logic [7:0] cmd, input logic [7:0] len,
                                              input logic [31:0] pay);
        logic [15:0] c;
        c = crc16_step(CRC_INIT, SYNC_BYTE);
        c = crc16_step(c, cmd);
        c = crc16_step(c, len);
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            if (k < len) c = crc16_step(c, (k < 4) ? pay[8*k +: 8] : 8'h00);
        end
        return c;
    endfunction

    function automatic void track_rx_byte(input logic [7:0] b);
        int k;
        t_frame_result res;
        if (p_idx != 0 || b == SYNC_BYTE) bytes_framed++;
        if (p_idx == 0) begin
            if (b == SYNC_BYTE) begin
                p_crc     = crc16_step(CRC_INIT, b);
                p_payload = '0;
                p_idx     = 4'd1;
            end
        end else if (p_idx == 1) begin
            p_cmd = b;
            p_crc = crc16_step(p_crc, b);
            p_idx = 4'd2;
        end else if (p_idx == 2) begin
            p_len = b;
            p_crc = crc16_step(p_crc, b);
            p_idx = 4'd3;
        end else if (p_idx < HDR_BYTES + PAYLOAD_BYTES) begin
            k = p_idx - HDR_BYTES;
            if (k < 4) p_payload[8*k +: 8] = b;
            if (k < p_len) p_crc = crc16_step(p_crc, b);
            p_idx = p_idx + 4'd1;
        end else if (p_idx < CRC_LO_POS) begin
            p_crc_hi = b;
            p_idx    = p_idx + 4'd1;
        end else begin
            // Last CRC byte: the frame is judged and the deframer goes back to hunting.
            p_idx = 4'd0;
            if (p_len != 0 && p_len <= PAYLOAD_BYTES && {p_crc_hi, b} == p_crc
                    && p_cmd != 0 && p_cmd <= MAX_CMD) begin
                if (p_cmd == CMD_LEFT) begin
                    p_left_fresh = 1'b1;
                end else if (p_cmd == CMD_RIGHT && p_left_fresh) begin
                    p_pairs      = p_pairs + 16'd1;
                    p_left_fresh = 1'b0;
                end
                res.cmd     = p_cmd[3:0];
                res.len     = p_len[2:0];
                res.payload = p_payload;
                res.pairs   = p_pairs;
                expected_frames.push_back(res);
            end
            p_crc = CRC_INIT;
        end
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pace_random ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        do @(posedge clk); while (in_stall);
        track_rx_byte(b);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                              input logic [31:0] pay, input logic [15:0] crc_flip);
        logic [15:0] c;
        c = frame_crc(cmd, len, pay) ^ crc_flip;
        send_byte(SYNC_BYTE);
        send_byte(cmd);
        send_byte(len);
        for (int k = 0; k < PAYLOAD_BYTES; k++) send_byte((k < 4) ? pay[8*k +: 8] : 8'h00);
        send_byte(c[15:8]);
        send_byte(c[7:0]);
    endtask

    always @(posedge clk) begin : check_results
        t_frame_result want;
        if (rst_n && out_valid && !out_stall) begin
            result_taken = 1'b1;
            if (expected_frames.size() == 0) begin
                note_failure($sformatf("unexpected frame: cmd %0d len %0d payload %h pairs %0d",
                                       frame_cmd, data_len, frame_payload, pair_count));
            end else begin
                want = expected_frames.pop_front();
                if (want.cmd !== frame_cmd || want.len !== data_len
                        || want.payload !== frame_payload || want.pairs !== pair_count) begin
                    note_failure($sformatf({"frame mismatch: expected cmd %0d len %0d ",
                                            "payload %h pairs %0d, got cmd %0d len %0d ",
                                            "payload %h pairs %0d"},
                        want.cmd, want.len, want.payload, want.pairs,
                        frame_cmd, data_len, frame_payload, pair_count));
                end
            end
        end
    end

    // Receiver pacing: a fresh wait is drawn after every taken result.
    initial begin : drive_out_stall
        int wait_left;
        wait_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (result_taken) begin
                result_taken = 1'b0;
                wait_left    = pace_random ? $urandom_range(0, 15) : 0;
            end
            out_stall = hold_block || (wait_left > 0);
            if (wait_left > 0) wait_left--;
        end
    end

    initial begin : long_hold_off
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_block    = 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_block = 1'b0;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_serial_frame_receive_checker_core failed");
        $finish;
    end

    task automatic test_sync_hunt();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'h54);
        send_byte(8'h56);
        // Bytes beyond the length are carried but not covered by the CRC.
        send_frame(8'd9, 8'd1, 32'hFFFF_FFFF, 16'h0000);
        send_frame(8'd3, 8'd4, 32'h0000_0000, 16'h0000);
    endtask

    task automatic test_sync_in_frame();
        send_frame(8'd3, 8'd4, 32'h5555_5555, 16'h0000);
        send_frame(8'd5, 8'd2, 32'h0055_0055, 16'h0000);
    endtask

    task automatic test_length_limits();
        send_frame(8'd4, 8'd0, 32'h1234_5678, 16'h0000);
        send_frame(8'd4, 8'd5, 32'h1234_5678, 16'h0000);
        send_frame(8'd4, 8'd255, 32'h1234_5678, 16'h0000);
        send_frame(8'd6, 8'd3, 32'hFFFF_FFFF, 16'h0000);
    endtask

    task automatic test_crc_mismatch();
        send_frame(8'd7, 8'd2, 32'hA5A5_5A5A, 16'h0001);
        send_frame(8'd7, 8'd2, 32'hA5A5_5A5A, 16'h8000);
        send_frame(8'd7, 8'd2, 32'hA5A5_5A5A, 16'h0000);
    endtask

    task automatic test_command_limits();
        send_frame(8'd0, 8'd1, 32'h0000_00C3, 16'h0000);
        send_frame(8'd10, 8'd1, 32'h0000_00C3, 16'h0000);
        send_frame(8'd255, 8'd1, 32'h0000_00C3, 16'h0000);
        send_frame(8'd8, 8'd1, 32'h0000_00C3, 16'h0000);
    endtask

    task automatic test_pairing();
        // A right frame with no left frame pending leaves the count alone.
        send_frame(CMD_RIGHT, 8'd4, 32'h0102_0304, 16'h0000);
        send_frame(CMD_LEFT, 8'd4, 32'h1111_1111, 16'h0000);
        send_frame(CMD_LEFT, 8'd4, 32'h2222_2222, 16'h0000);
        send_frame(CMD_RIGHT, 8'd4, 32'h3333_3333, 16'h0000);
        send_frame(CMD_RIGHT, 8'd4, 32'h4444_4444, 16'h0000);
        send_frame(CMD_LEFT, 8'd4, 32'h5555_5555, 16'h0000);
        // Dropped frames in between keep the pending left frame.
        send_frame(CMD_RIGHT, 8'd4, 32'h6666_6666, 16'h0100);
        send_frame(8'd0, 8'd4, 32'h7777_7777, 16'h0000);
        send_frame(CMD_RIGHT, 8'd4, 32'h8888_8888, 16'h0000);
    endtask

    task automatic test_back_pressure();
        pace_random   = 1'b0;
        long_hold_req = 1'b1;
        repeat (8) send_frame(8'($urandom_range(1, 2)), 8'd4, $urandom, 16'h0000);
    endtask

    task automatic test_random_traffic();
        int          bytes_start;
        int          pick;
        logic [7:0]  cmd;
        logic [7:0]  len;
        logic [15:0] flip;
        bytes_start = bytes_framed;
        while (bytes_framed - bytes_start < RANDOM_BYTES) begin
            if ($urandom_range(0, 7) == 0) pace_random = ~pace_random;
            pick = $urandom_range(0, 19);
            if ($urandom_range(0, 9) == 0) begin
                cmd = 8'($urandom);
            end else begin
                cmd = $urandom_range(0, 1) ? 8'($urandom_range(1, 2))
                                           : 8'($urandom_range(1, 9));
            end
            len  = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                               : 8'($urandom_range(1, PAYLOAD_BYTES));
            flip = (pick < 4) ? (16'd1 << $urandom_range(0, 15)) : 16'h0000;
            if (pick < 2) begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end else begin
                send_frame(cmd, len, $urandom, flip);
            end
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rx_byte      = 8'h00;
        p_idx        = 4'd0;
        p_crc        = CRC_INIT;
        p_cmd        = 8'h00;
        p_len        = 8'h00;
        p_payload    = '0;
        p_crc_hi     = 8'h00;
        p_left_fresh = 1'b0;
        p_pairs      = 16'h0000;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_sync_hunt();
        test_sync_in_frame();
        test_length_limits();
        test_crc_mismatch();
        test_command_limits();
        test_pairing();
        test_back_pressure();
        test_random_traffic();

        in_valid = 1'b0;
        for (int n = 0; n < EMPTY_GUARD && expected_frames.size() != 0; n++) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_frames.size() != 0) begin
            note_failure($sformatf("%0d expected frames never arrived", expected_frames.size()));
        end
        if (failures == 0) begin
            $display("tb_serial_frame_receive_checker_core passed");
        end else begin
            $display("tb_serial_frame_receive_checker_core failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/sfrc_pkg.sv
sv/sfrc_deframer.sv
sv/serial_frame_receive_checker_core.sv
dv/tb_serial_frame_receive_checker_core.sv
